// ----- rtl/core/shash_pkg.sv -----
`default_nettype none

package shash_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned ChainWords = 8;
  localparam int unsigned WindowWords = 16;

  localparam logic [31:0] ROUND_K [0:RoundCount-1] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INITIAL_HASH [0:ChainWords-1] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sha256_stream_hasher.sv -----
`default_nettype none

// SHA-256 over a byte stream. Each transaction on the input channel carries at most one
// message byte and may close the message; a closing transaction leads, after padding and
// compression, to eight transactions on the output channel, digest word 0 first. While
// bytes are being gathered one transaction is taken per cycle; the transaction that
// completes a 64-byte block then holds the input while one shared round unit runs
// the 64 rounds one per cycle and a final add step adds the result into the chaining
// value. After a closing transaction the pad, zero fill and length are written one byte
// per cycle (up to 64, or up to 72 when an extra block is needed), each padded block is
// compressed in the same way, and the input stays stalled until the eighth digest word has
// been taken. Bytes past the 2^61-1 byte limit are dropped and flagged on every digest word.
module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_number,
  output logic             out_last_word,
  output logic             out_length_overflow
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic        ovf_r, ovf_nxt;
  logic        pad_r, pad_nxt;
  logic        p80_r, p80_nxt;
  logic        len_ok_r, len_ok_nxt;
  logic        final_r, final_nxt;
  logic [5:0]  round_r, round_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic [31:0] w_r [0:shash_pkg::WindowWords-1];
  logic [31:0] v_r [0:shash_pkg::ChainWords-1];
  logic [31:0] chain_r [0:shash_pkg::ChainWords-1];

  logic        in_acc;
  logic        out_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic        start_comp;
  logic        msg_done;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_acc  = out_valid && out_ready;
  assign msg_done = out_acc && (idx_r == 3'd7);

  assign out_digest_word     = chain_r[0];
  assign out_word_number     = idx_r;
  assign out_last_word       = (idx_r == 3'd7);
  assign out_length_overflow = ovf_r;

  assign bit_len  = {msg_r, 3'b000};
  assign len_byte = bit_len[{~fill_r[2:0], 3'b000} +: 8];

  assign t1 = v_r[7] + shash_pkg::big_sigma1(v_r[4]) +
              ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
              shash_pkg::ROUND_K[round_r] + w_r[0];
  assign t2 = shash_pkg::big_sigma0(v_r[0]) +
              ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = w_r[0] + shash_pkg::small_sigma0(w_r[1]) + w_r[9] +
                 shash_pkg::small_sigma1(w_r[14]);

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    msg_nxt    = msg_r;
    ovf_nxt    = ovf_r;
    pad_nxt    = pad_r;
    p80_nxt    = p80_r;
    len_ok_nxt = len_ok_r;
    final_nxt  = final_r;
    round_nxt  = round_r;
    idx_nxt    = idx_r;
    wr_en      = 1'b0;
    wr_byte    = in_data_byte;
    start_comp = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            if (&msg_r) begin
              ovf_nxt = 1'b1;
            end else begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + 6'd1;
              msg_nxt  = msg_r + 61'd1;
              if (fill_r == 6'd63) begin
                start_comp = 1'b1;
              end
            end
          end
          if (in_end_of_message) begin
            pad_nxt = 1'b1;
            state_nxt = S_PAD;
          end
          if (start_comp) begin
            state_nxt = S_ROUND;
          end
        end
      end
      S_PAD: begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (!p80_r) begin
          wr_byte    = shash_pkg::PAD_BYTE;
          p80_nxt    = 1'b1;
          len_ok_nxt = (fill_r[5:3] != 3'b111);
        end else if (len_ok_r && (fill_r[5:3] == 3'b111)) begin
          wr_byte = len_byte;
        end else begin
          wr_byte = 8'h00;
        end
        if (fill_r == 6'd63) begin
          start_comp = 1'b1;
          final_nxt  = p80_r && len_ok_r;
          state_nxt  = S_ROUND;
        end
      end
      S_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (final_r) begin
          idx_nxt   = 3'd0;
          state_nxt = S_OUT;
        end else if (pad_r) begin
          len_ok_nxt = 1'b1;
          state_nxt  = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            state_nxt  = S_IDLE;
            fill_nxt   = 6'd0;
            msg_nxt    = 61'd0;
            ovf_nxt    = 1'b0;
            pad_nxt    = 1'b0;
            p80_nxt    = 1'b0;
            len_ok_nxt = 1'b0;
            final_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (start_comp) begin
      round_nxt = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 6'd0;
      msg_r    <= 61'd0;
      ovf_r    <= 1'b0;
      pad_r    <= 1'b0;
      p80_r    <= 1'b0;
      len_ok_r <= 1'b0;
      final_r  <= 1'b0;
      round_r  <= 6'd0;
      idx_r    <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      msg_r    <= msg_nxt;
      ovf_r    <= ovf_nxt;
      pad_r    <= pad_nxt;
      p80_r    <= p80_nxt;
      len_ok_r <= len_ok_nxt;
      final_r  <= final_nxt;
      round_r  <= round_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (fill_r[1:0])
        2'd0: w_r[fill_r[5:2]][31:24] <= wr_byte;
        2'd1: w_r[fill_r[5:2]][23:16] <= wr_byte;
        2'd2: w_r[fill_r[5:2]][15:8]  <= wr_byte;
        2'd3: w_r[fill_r[5:2]][7:0]   <= wr_byte;
        default: w_r[fill_r[5:2]][7:0] <= wr_byte;
      endcase
    end else if (state_r == S_ROUND) begin
      for (int k = 0; k < shash_pkg::WindowWords - 1; k++) begin
        w_r[k] <= w_r[k+1];
      end
      w_r[shash_pkg::WindowWords-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (start_comp) begin
      for (int k = 0; k < shash_pkg::ChainWords; k++) begin
        v_r[k] <= chain_r[k];
      end
    end else if (state_r == S_ROUND) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || msg_done) begin
      for (int k = 0; k < shash_pkg::ChainWords; k++) begin
        chain_r[k] <= shash_pkg::INITIAL_HASH[k];
      end
    end else if (state_r == S_ADD) begin
      for (int k = 0; k < shash_pkg::ChainWords; k++) begin
        chain_r[k] <= chain_r[k] + v_r[k];
      end
    end else if (out_acc) begin
      for (int k = 0; k < shash_pkg::ChainWords - 1; k++) begin
        chain_r[k] <= chain_r[k+1];
      end
      chain_r[shash_pkg::ChainWords-1] <= chain_r[0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/shash_checker.sv -----
`default_nettype none

module shash_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_end_of_message,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_number,
  input wire logic        out_last_word,
  input wire logic        out_length_overflow
);

  // A closing transaction must be followed by a stalled input.
  a_close_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_message |=> !in_ready)
    else $error("input ready straight after a closing transaction");

  // Digest words follow one another without gaps until the last one.
  a_word_sequence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && (out_word_number == $past(out_word_number) + 3'd1))
    else $error("digest words out of sequence");

  // The input is never taken while a digest is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a digest word is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word) &&
      $stable(out_word_number) && $stable(out_length_overflow))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (.*);

`default_nettype wire

// ----- dv/sha256_digest_check.sv -----
module sha256_digest_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_end_of_message,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [31:0]       out_digest_word,
  input  logic [2:0]        out_word_number,
  input  logic              out_last_word,
  input  logic              out_length_overflow,
  output int unsigned       pending_words,
  output int unsigned       mismatch_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
    logic        overflow;
  } digest_entry_t;

  digest_entry_t expected_words [$];
  digest_entry_t want;

  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_level;
  logic [60:0] bytes_taken;
  logic        bytes_dropped;
  logic [63:0] bit_len;

  initial begin
    pending_words = 0;
    mismatch_count = 0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = shash_pkg::INITIAL_HASH[i];
    block_level = 0;
    bytes_taken = '0;
    bytes_dropped = 1'b0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shash_pkg::ROUND_K[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] wanted);
    mismatch_count++;
    if (mismatch_count <= 200) begin
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, wanted);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_message();
      expected_words.delete();
      pending_words <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_has_byte) begin
          if (bytes_taken != '1) begin
            block_bytes[block_level] = in_data_byte;
            block_level++;
            bytes_taken++;
            if (block_level == 64) begin
              compress_block();
              block_level = 0;
            end
          end else begin
            bytes_dropped = 1'b1;
          end
        end
        if (in_end_of_message) begin
          bit_len = {bytes_taken, 3'b000};
          block_bytes[block_level] = shash_pkg::PAD_BYTE;
          block_level++;
          if (block_level > 56) begin
            while (block_level < 64) begin
              block_bytes[block_level] = 8'h00;
              block_level++;
            end
            compress_block();
            block_level = 0;
          end
          while (block_level < 56) begin
            block_bytes[block_level] = 8'h00;
            block_level++;
          end
          for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
          compress_block();
          for (int i = 0; i < 8; i++) begin
            expected_words.push_back('{word: hash_state[i], index: 3'(i),
                                       last: (i == 7), overflow: bytes_dropped});
          end
          restart_message();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          flag_mismatch("digest word with nothing expected", out_digest_word, 32'h0);
        end else begin
          want = expected_words.pop_front();
          if (out_digest_word !== want.word) begin
            flag_mismatch("digest_word", out_digest_word, want.word);
          end
          if (out_word_number !== want.index) begin
            flag_mismatch("word_number", 32'(out_word_number), 32'(want.index));
          end
          if (out_last_word !== want.last) begin
            flag_mismatch("last_word", 32'(out_last_word), 32'(want.last));
          end
          if (out_length_overflow !== want.overflow) begin
            flag_mismatch("length_overflow", 32'(out_length_overflow), 32'(want.overflow));
          end
        end
      end
      pending_words <= expected_words.size();
    end
  end

endmodule

// ----- dv/tb_sha256_stream_hasher.sv -----
module tb_sha256_stream_hasher;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  logic        out_last_word;
  logic        out_length_overflow;

  int unsigned pending_words;
  int unsigned mismatch_count;
  int unsigned items_counted = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  int unsigned pad_boundary_len [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  sha256_stream_hasher dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_has_byte         (in_has_byte),
    .in_end_of_message   (in_end_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_digest_word     (out_digest_word),
    .out_word_number     (out_word_number),
    .out_last_word       (out_last_word),
    .out_length_overflow (out_length_overflow)
  );

  sha256_digest_check digest_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_has_byte         (in_has_byte),
    .in_end_of_message   (in_end_of_message),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_digest_word     (out_digest_word),
    .out_word_number     (out_word_number),
    .out_last_word       (out_last_word),
    .out_length_overflow (out_length_overflow),
    .pending_words       (pending_words),
    .mismatch_count      (mismatch_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The receiver stalls at random unless steady; on request it times a long hold-off.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  task automatic offer_item(input logic [7:0] data, input bit has_byte, input bit closes);
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      in_data_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_has_byte <= has_byte;
    in_end_of_message <= closes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_counted++;
  endtask

  task automatic send_message(input int unsigned len, input bit close_on_byte);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(99) < 6) offer_item(8'($urandom_range(255)), 1'b0, 1'b0);
      offer_item(8'($urandom_range(255)), 1'b1, close_on_byte && (k == len - 1));
    end
    if (!close_on_byte || len == 0) offer_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned msg_index;
    int unsigned len;
    int unsigned pick;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The empty message, then a short one closed by a transaction without a byte.
    offer_item(8'h00, 1'b0, 1'b1);
    offer_item(8'h61, 1'b1, 1'b0);
    offer_item(8'h62, 1'b1, 1'b0);
    offer_item(8'h63, 1'b1, 1'b0);
    offer_item(8'hff, 1'b0, 1'b1);
    drain_digests();
    offer_item(8'h00, 1'b1, 1'b0);
    offer_item(8'hff, 1'b0, 1'b0);
    offer_item(8'hff, 1'b1, 1'b0);
    offer_item(8'h00, 1'b1, 1'b1);
    offer_item(8'ha5, 1'b1, 1'b1);

    // Hold the receiver off while the sender keeps going, so the input backs up.
    hold_req = 1'b1;
    send_message(20, 1'b1);
    send_message(12, 1'b0);
    drain_digests();

    msg_index = 0;
    while (items_counted < 500 || msg_index < 12) begin
      steady = (msg_index >= 6 && msg_index < 12);
      pick = $urandom_range(99);
      if (pick < 65) begin
        len = $urandom_range(12);
      end else if (pick < 85) begin
        len = pad_boundary_len[$urandom_range(9)];
      end else begin
        len = $urandom_range(200);
      end
      send_message(len, 1'($urandom_range(1)));
      if (msg_index % 8 == 7) drain_digests();
      msg_index++;
    end
    steady = 1'b0;

    drain_digests();
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** sha256_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_stream_hasher: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/shash_pkg.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/shash_checker.sv
dv/sha256_digest_check.sv
dv/tb_sha256_stream_hasher.sv
